// File: hdl/lawc_pkg.sv
// ----------------------------------------------------------------------------
// Line assembler package
// Shared constants and types for the front queue and the line sequencer.
// ----------------------------------------------------------------------------
package lawc_pkg;

   localparam int LINE_BYTES  = 64;
   localparam int ADDR_W      = $clog2(LINE_BYTES);
   localparam int MAX_LINE_W  = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] NL_CODE  = 8'h0A;
   localparam logic [7:0] BSL_CODE = 8'h5C;
   localparam logic [7:0] EOF_CODE = 8'hFF;

   localparam logic ACTION_TEXT = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic STATUS_LINE   = 1'b0;
   localparam logic STATUS_NOLINE = 1'b1;

   // Classified input item.
   typedef enum logic [1:0] {
      KIND_TEXT    = 2'd0,
      KIND_NEWLINE = 2'd1,
      KIND_EOFB    = 2'd2,
      KIND_END     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } q_item_type;

endpackage

// File: hdl/lawc_front.sv
// ----------------------------------------------------------------------------
// Line assembler front end
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module lawc_front import lawc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   output logic       q_valid,
   output q_item_type q_item,
   input  logic       q_pop
);

   q_item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   logic                  push;
   q_item_type            new_item;

   assign req_stall = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.data = req_data_byte;
      if (req_action == ACTION_END) begin
         new_item.kind = KIND_END;
      end else if (req_data_byte == NL_CODE) begin
         new_item.kind = KIND_NEWLINE;
      end else if (req_data_byte == EOF_CODE) begin
         new_item.kind = KIND_EOFB;
      end else begin
         new_item.kind = KIND_TEXT;
      end
   end

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: hdl/lawc_back.sv
// ----------------------------------------------------------------------------
// Line assembler back end
// Owns the line store, fill count and discard flag; sequences line output.
// ----------------------------------------------------------------------------
module lawc_back import lawc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [MAX_LINE_W-1:0] max_line,
   input  logic                  q_valid,
   input  q_item_type            q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   output logic                  rsp_status,
   output logic [ADDR_W-1:0]     rsp_line_length
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_TAIL   = 6'b000010,
      ST_RD     = 6'b000100,
      ST_OUT    = 6'b001000,
      ST_NL     = 6'b010000,
      ST_NOLINE = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  fill_ff, fill_in;
   logic               disc_ff, disc_in;
   logic [7:0]         tail_ff, tail_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  len_ff, len_in;
   logic [7:0]         line_mem [LINE_BYTES];
   logic [7:0]         rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  limit;
   logic               pre_disc;
   logic [ADDR_W-1:0]  pre_fill;
   logic               tail_bsl;
   logic               out_free;
   logic               load;
   logic [7:0]         ld_byte;
   logic               ld_last;
   logic               ld_status;
   logic [ADDR_W-1:0]  ld_len;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         out_byte_ff;
   logic               last_ff;
   logic               status_ff;
   logic [ADDR_W-1:0]  length_ff;

   // Overflow limit: clamped line size minus one.
   always_comb begin
      if (max_line < MAX_LINE_W'(2)) begin
         limit = ADDR_W'(1);
      end else if (max_line > MAX_LINE_W'(LINE_BYTES)) begin
         limit = ADDR_W'(LINE_BYTES - 1);
      end else begin
         limit = ADDR_W'(max_line - MAX_LINE_W'(1));
      end
   end

   // Enter discard mode before the item when the line already hit the limit.
   assign pre_disc = disc_ff || (fill_ff >= limit);
   assign pre_fill = pre_disc ? '0 : fill_ff;
   assign tail_bsl = (tail_ff == BSL_CODE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      disc_in   = disc_ff;
      tail_in   = tail_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      q_pop     = 1'b0;
      load      = 1'b0;
      ld_byte   = 8'h00;
      ld_last   = 1'b0;
      ld_status = STATUS_LINE;
      ld_len    = len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               disc_in = pre_disc;
               fill_in = pre_fill;
               case (q_item.kind)
                  KIND_END: begin
                     fill_in = '0;
                     disc_in = 1'b0;
                     if (pre_disc || pre_fill == '0 || tail_bsl) begin
                        state_in = ST_NOLINE;
                     end else begin
                        len_in   = pre_fill;
                        idx_in   = '0;
                        state_in = ST_RD;
                     end
                  end
                  KIND_NEWLINE: begin
                     if (pre_disc) begin
                        disc_in  = 1'b0;
                        fill_in  = '0;
                        len_in   = '0;
                        state_in = ST_NL;
                     end else if (pre_fill != '0 && tail_bsl) begin
                        // drop the backslash and fetch the byte it exposes
                        fill_in = pre_fill - 1'b1;
                        rd_addr = pre_fill - ADDR_W'(2);
                        if (pre_fill != ADDR_W'(1)) begin
                           state_in = ST_TAIL;
                        end
                     end else begin
                        fill_in = '0;
                        len_in  = pre_fill;
                        idx_in  = '0;
                        state_in = (pre_fill == '0) ? ST_NL : ST_RD;
                     end
                  end
                  KIND_EOFB: begin
                     if (pre_disc) begin
                        state_in = ST_NOLINE;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = q_item.data;
                        fill_in = pre_fill + 1'b1;
                     end
                  end
                  KIND_TEXT: begin
                     if (!pre_disc) begin
                        wr_en   = 1'b1;
                        tail_in = q_item.data;
                        fill_in = pre_fill + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TAIL: begin
            tail_in  = rd_data_ff;
            state_in = ST_IDLE;
         end
         ST_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               load    = 1'b1;
               ld_byte = rd_data_ff;
               if (idx_ff == len_ff - 1'b1) begin
                  state_in = ST_NL;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         ST_NL: begin
            if (out_free) begin
               load     = 1'b1;
               ld_byte  = NL_CODE;
               ld_last  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_NOLINE: begin
            if (out_free) begin
               load      = 1'b1;
               ld_last   = 1'b1;
               ld_status = STATUS_NOLINE;
               ld_len    = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         disc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         disc_ff      <= disc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      idx_ff  <= idx_in;
      len_ff  <= len_in;
      if (load) begin
         out_byte_ff <= ld_byte;
         last_ff     <= ld_last;
         status_ff   <= ld_status;
         length_ff   <= ld_len;
      end
   end

   // Line store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[pre_fill] <= q_item.data;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;
   assign rsp_line_length = length_ff;

   a_disc_empty: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> fill_ff == '0)
      else $error("discard mode with nonzero fill count");

   a_out_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> $past(state_ff) == ST_RD || $past(state_ff) == ST_OUT)
      else $error("line byte presented without a store read");

   a_rd_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> len_ff != '0 && idx_ff < len_ff)
      else $error("store read outside the emitted line");

   a_last_source: assert property (@(posedge clock) disable iff (reset)
      load && ld_last |-> state_ff == ST_NL || state_ff == ST_NOLINE)
      else $error("final result loaded outside a closing state");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> !$past(q_pop))
      else $error("queue popped while a line is in progress");

endmodule

// File: hdl/line_assembler_with_continuation_core.sv
// ----------------------------------------------------------------------------
// Line assembler with backslash continuation
// Builds text lines from a byte stream and emits them one byte per result.
//
// Input channel (req_): one item per transfer, either a text byte
// (req_action = 0) or an end-of-data mark (req_action = 1). Items enter a
// two-entry queue; req_stall rises only when that queue is full.
// Result channel (rsp_): one result per transfer from an output register.
// A line of n bytes yields n byte results and a newline result with
// rsp_last set; no-line results carry rsp_status = 1 and rsp_last = 1.
// Sequencing: a removed continuation backslash triggers a store read that
// refreshes the tail byte (none if the line empties), and each line byte
// passes a read state and an output state, set by the single registered
// read port of the line store. Reset clears the queue, fill count, discard
// mode and output valid, and sets max_line to 64; the line store is not
// cleared. While rsp_stall is high with a valid result, the result register
// holds and emission pauses; the queue fills while the sequencer waits.
// csr_write_enable writes max_line; write it only while the block is idle.
// ----------------------------------------------------------------------------
module line_assembler_with_continuation_core import lawc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [MAX_LINE_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   output logic                  rsp_status,
   output logic [ADDR_W-1:0]     rsp_line_length
);

   logic [MAX_LINE_W-1:0] max_line_ff, max_line_in;
   logic                  q_valid;
   q_item_type            q_item;
   logic                  q_pop;

   assign max_line_in = csr_write_enable ? csr_write_data : max_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= MAX_LINE_W'(LINE_BYTES);
      end else begin
         max_line_ff <= max_line_in;
      end
   end

   lawc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   lawc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .max_line        (max_line_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_line_length (rsp_line_length)
   );

endmodule
